>>> design/sfd_pkg.sv
// Package for the stereo feedback delay: sample and gain types, register
// indexes, reset values and the saturation helper. Depends on nothing.
`default_nettype none

package sfd_pkg;

	typedef logic signed [15:0] sample_t;
	typedef logic [1:0]         cfg_idx_t;

	localparam int CFG_DW  = 18;
	localparam int DELAY_W = 18;
	localparam int FB_W    = 15;
	localparam int MIX_W   = 16;

	localparam cfg_idx_t REG_DELAY    = 2'd0;
	localparam cfg_idx_t REG_FEEDBACK = 2'd1;
	localparam cfg_idx_t REG_WET_MIX  = 2'd2;

	localparam int DELAY_RESET = 22050;
	localparam logic [FB_W-1:0]  FB_RESET  = 15'd16384;
	localparam logic [FB_W-1:0]  FB_MAX    = 15'd31130;
	localparam logic [MIX_W-1:0] MIX_RESET = 16'd16384;
	localparam logic [MIX_W-1:0] ONE_Q15   = 16'd32768;

	typedef struct packed {
		logic [FB_W-1:0]  fb;
		logic [MIX_W-1:0] wet;
		logic [MIX_W-1:0] dry;
	} gain_t;

	function automatic sample_t sat16(input logic signed [33:0] v);
		sample_t r;
		if (v > 34'sd32767) begin
			r = 16'sh7FFF;
		end else if (v < -34'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

>>> design/sfd_in_if.sv
// Input channel of the stereo feedback delay: valid/ready handshake and
// one stereo sample pair. Depends on sfd_pkg.
`default_nettype none

interface sfd_in_if;
	import sfd_pkg::*;

	logic    valid;
	logic    ready;
	sample_t left_in;
	sample_t right_in;

	modport source (output valid, output left_in, output right_in, input ready);
	modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

`default_nettype wire

>>> design/sfd_out_if.sv
// Output channel of the stereo feedback delay: valid/ready handshake and
// one mixed stereo sample pair. Depends on sfd_pkg.
`default_nettype none

interface sfd_out_if;
	import sfd_pkg::*;

	logic    valid;
	logic    ready;
	sample_t left_out;
	sample_t right_out;

	modport source (output valid, output left_out, output right_out, input ready);
	modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

`default_nettype wire

>>> design/sfd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. Depends on nothing.
`default_nettype none

module sfd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

`default_nettype wire

>>> design/sfd_lane.sv
// One channel lane of the stereo feedback delay: feedback and mix products,
// then rounding and saturation. Depends on sfd_pkg.
`default_nettype none

module sfd_lane (
	input  logic            clk,
	input  logic            en,
	input  sfd_pkg::sample_t dly,
	input  sfd_pkg::sample_t xin,
	input  sfd_pkg::gain_t   gain,
	output sfd_pkg::sample_t stored,
	output sfd_pkg::sample_t result
);
	import sfd_pkg::*;

	logic signed [31:0] fb_prod;
	logic signed [32:0] dry_prod;
	logic signed [32:0] wet_prod;
	logic signed [31:0] fb_prod_s2;
	logic signed [32:0] dry_prod_s2;
	logic signed [32:0] wet_prod_s2;
	sample_t            xin_s2;

	logic signed [31:0] fb_sum;
	logic signed [31:0] fb_shift;
	logic signed [17:0] st_sum;
	logic signed [33:0] mix_sum;
	logic signed [33:0] mix_shift;

	assign fb_prod  = dly * $signed({1'b0, gain.fb});
	assign dry_prod = xin * $signed({1'b0, gain.dry});
	assign wet_prod = dly * $signed({1'b0, gain.wet});

	always_ff @(posedge clk) begin
		if (en) begin
			fb_prod_s2  <= fb_prod;
			dry_prod_s2 <= dry_prod;
			wet_prod_s2 <= wet_prod;
			xin_s2      <= xin;
		end
	end

	// Both shifts round half up: bias by one half, then shift arithmetically.
	always_comb begin
		fb_sum    = fb_prod_s2 + 32'sd16384;
		fb_shift  = fb_sum >>> 15;
		st_sum    = $signed({{2{xin_s2[15]}}, xin_s2}) + $signed(fb_shift[17:0]);
		mix_sum   = $signed({dry_prod_s2[32], dry_prod_s2})
		          + $signed({wet_prod_s2[32], wet_prod_s2}) + 34'sd16384;
		mix_shift = mix_sum >>> 15;
		stored    = sat16($signed({{16{st_sum[17]}}, st_sum}));
		result    = sat16(mix_shift);
	end
endmodule

`default_nettype wire

>>> design/stereo_feedback_delay.sv
// Top level of the stereo feedback delay: configuration registers, delay
// store, pointers and the two channel lanes. Depends on sfd_pkg, the
// channel interfaces, sfd_ram and sfd_lane.
//
// Usage: each transfer on src carries one left/right Q1.15 sample pair; each
// transfer on snk returns the dry/wet mixed pair for it, one result per
// input and in order. The configuration port is a plain write port
// (cfg_we, cfg_idx, cfg_data); the user writes it only while the block is
// idle, which the block itself does not enforce. An input pair passes through
// stage one, stage two and the output register before its result is valid.
// A new pair is taken only while stage one is empty; the delay store has one
// read and one write port, and each item reads its delayed pair when it is
// taken and writes its new pair when it leaves the second stage. Reset clears
// the pointers, the fill count and the pipeline, and loads the register reset
// values. The store itself is not swept: a fill count tells which entries
// were written since reset, and entries not yet written read as zero.
// When the receiver stalls, the result waits in the output register, one
// more pair can enter and wait in the pipeline, and then src.ready drops.
`default_nettype none

module stereo_feedback_delay #(
	parameter int STORE_DEPTH = 131072
) (
	input  logic                       clk,
	input  logic                       arst_n,
	sfd_in_if.sink                     src,
	sfd_out_if.source                  snk,
	input  logic                       cfg_we,
	input  sfd_pkg::cfg_idx_t          cfg_idx,
	input  logic [sfd_pkg::CFG_DW-1:0] cfg_data
);
	import sfd_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int DW = $clog2(STORE_DEPTH + 1);
	localparam logic [DW-1:0] DELAY_RST =
		DW'((DELAY_RESET > STORE_DEPTH) ? STORE_DEPTH : DELAY_RESET);
	localparam logic [DW-1:0] DEPTH_D = DW'(STORE_DEPTH);
	localparam logic [AW-1:0] LAST_AW = AW'(STORE_DEPTH - 1);

	// Configuration registers. Values are clipped when written, so the
	// datapath only ever sees the effective delay and gains.
	logic [DW-1:0]      delay_q;
	gain_t              gain_q;
	logic [DELAY_W-1:0] dly_wr;
	logic [FB_W-1:0]    fb_wr;
	logic [MIX_W-1:0]   mix_wr;
	logic [MIX_W-1:0]   mix_clip;

	assign dly_wr   = cfg_data[DELAY_W-1:0];
	assign fb_wr    = cfg_data[FB_W-1:0];
	assign mix_wr   = cfg_data[MIX_W-1:0];
	assign mix_clip = (mix_wr > ONE_Q15) ? ONE_Q15 : mix_wr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q    <= DELAY_RST;
			gain_q.fb  <= FB_RESET;
			gain_q.wet <= MIX_RESET;
			gain_q.dry <= MIX_W'(17'd32768 - {1'b0, MIX_RESET});
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_DELAY: begin
					// Zero or anything past the store means the full store.
					if (dly_wr == '0 || 33'(dly_wr) > 33'(STORE_DEPTH)) begin
						delay_q <= DEPTH_D;
					end else begin
						delay_q <= DW'(dly_wr);
					end
				end
				REG_FEEDBACK: begin
					gain_q.fb <= (fb_wr > FB_MAX) ? FB_MAX : fb_wr;
				end
				REG_WET_MIX: begin
					gain_q.wet <= mix_clip;
					gain_q.dry <= MIX_W'(17'd32768 - {1'b0, mix_clip});
				end
				default: begin
				end
			endcase
		end
	end

	// Pipeline control. Stage one waits for the store read, stage two holds
	// the lane products, and the output register feeds snk.
	logic s1_valid_q, s2_valid_q, out_valid_q;
	logic accept, s1_adv, s2_adv;

	assign s2_adv    = s2_valid_q && (!out_valid_q || snk.ready);
	assign s1_adv    = s1_valid_q && (!s2_valid_q || s2_adv);
	assign src.ready = !s1_valid_q && (!s2_valid_q || s2_adv);
	assign accept    = src.valid && src.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				s2_valid_q <= 1'b1;
			end else if (s2_adv) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (snk.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Write pointer and fill count both move when an item is taken. The
	// fill count saturates at the store depth; a delay no larger than it
	// points at an entry that has been written since reset.
	logic [AW-1:0] wp_q;
	logic [DW-1:0] fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (accept) begin
			wp_q <= (wp_q == LAST_AW) ? '0 : wp_q + 1'b1;
			if (fill_q != DEPTH_D) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Read address: the write pointer minus the delay, modulo the depth.
	logic [DW:0]   wp_ext, d_ext, diff;
	logic [AW-1:0] rd_addr;
	logic          hit;

	always_comb begin
		wp_ext  = (DW+1)'(wp_q);
		d_ext   = {1'b0, delay_q};
		diff    = wp_ext - d_ext;
		rd_addr = (wp_ext >= d_ext) ? AW'(diff) : AW'(diff + (DW+1)'(STORE_DEPTH));
		hit     = delay_q <= fill_q;
	end

	// Stage one registers. When the previous item writes the very entry this
	// one reads at the same edge, its new word is forwarded instead.
	sample_t       xin_s1 [2];
	logic [AW-1:0] wp_s1, wp_s2;
	logic          hit_s1, fwd_s1;
	logic [31:0]   fwd_word_s1;
	logic [31:0]   st_word;
	logic [31:0]   rd_word;
	logic [31:0]   dly_word;
	sample_t       st_lane  [2];
	sample_t       res_lane [2];

	assign st_word = {st_lane[1], st_lane[0]};

	always_ff @(posedge clk) begin
		if (accept) begin
			xin_s1[0]   <= src.left_in;
			xin_s1[1]   <= src.right_in;
			wp_s1       <= wp_q;
			hit_s1      <= hit;
			fwd_s1      <= s2_adv && (rd_addr == wp_s2);
			fwd_word_s1 <= st_word;
		end
		if (s1_adv) begin
			wp_s2 <= wp_s1;
		end
	end

	sfd_ram #(
		.WIDTH (32),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (s2_adv),
		.waddr (wp_s2),
		.wdata (st_word),
		.re    (accept),
		.raddr (rd_addr),
		.rdata (rd_word)
	);

	always_comb begin
		if (fwd_s1) begin
			dly_word = fwd_word_s1;
		end else if (hit_s1) begin
			dly_word = rd_word;
		end else begin
			dly_word = '0;
		end
	end

	// Left lives in the low half of a store word, right in the high half.
	for (genvar i = 0; i < 2; i++) begin : g_lane
		sfd_lane u_lane (
			.clk    (clk),
			.en     (s1_adv),
			.dly    (dly_word[16*i +: 16]),
			.xin    (xin_s1[i]),
			.gain   (gain_q),
			.stored (st_lane[i]),
			.result (res_lane[i])
		);
	end

	// Merge the lanes into the output register.
	sample_t left_q, right_q;

	always_ff @(posedge clk) begin
		if (s2_adv) begin
			left_q  <= res_lane[0];
			right_q <= res_lane[1];
		end
	end

	assign snk.valid     = out_valid_q;
	assign snk.left_out  = left_q;
	assign snk.right_out = right_q;
endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for stereo_feedback_delay: a directed table, then random
// phases of stereo samples under changing register settings, with handshake stalls.
// Depends on sfd_pkg, sfd_in_if, sfd_out_if and the design top level.
module tb;
	import sfd_pkg::*;

	// The store depth is passed to the design so that the predictor and the block
	// agree on where the circular store wraps.
	localparam int ECHO_DEPTH = 131072;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 19;
	localparam int PAIRS_PER_PHASE = 100;

	// The design decodes three register indexes; the fourth must be ignored.
	localparam cfg_idx_t REG_UNUSED = 2'd3;

	typedef struct packed {
		sample_t left;
		sample_t right;
	} pair_t;

	typedef enum logic {ROW_PAIR, ROW_CFG} row_kind_t;

	// One row of the directed table: either a register write or a sample pair.
	// Where typed is set, the expected mix is written into the row itself;
	// otherwise the predictor supplies it.
	typedef struct packed {
		row_kind_t         kind;
		cfg_idx_t          idx;
		logic [CFG_DW-1:0] data;
		sample_t           left;
		sample_t           right;
		logic              typed;
		sample_t           want_l;
		sample_t           want_r;
	} step_row_t;

	localparam step_row_t DIRECTED [34] = '{
		// Reset settings: delay 22050, feedback one half, wet one half. The store
		// reads zero, so the output is the input halved with rounding half up.
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh4000, 16'shC000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh8000, 16'sh7FFF, 1'b1, 16'shC000, 16'sh4000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh0001, 16'shFFFF, 1'b1, 16'sh0001, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh0000, 16'sh0000, 1'b1, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh5555, 16'shAAAA, 1'b0, 16'sh0000, 16'sh0000},
		// Fully dry, and a zero delay that stands for the whole store depth:
		// the output is the input unchanged.
		'{ROW_CFG, REG_WET_MIX, 18'd0, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_CFG, REG_DELAY, 18'd0, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh1234, 16'shEDCB, 1'b1, 16'sh1234, 16'shEDCB},
		// Every register above its range: the mix clamps to fully wet, the delay
		// to the store depth and the feedback to 0.95. A write to the unused
		// index must change nothing. The tap is an entry never written.
		'{ROW_CFG, REG_WET_MIX, 18'd65535, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_CFG, REG_DELAY, 18'd262143, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_CFG, REG_FEEDBACK, 18'd32767, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_CFG, REG_UNUSED, 18'h3FFFF, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh0000, 16'sh0000},
		// A delay of one reads back the pair written just before; with full-scale
		// inputs the feedback path saturates.
		'{ROW_CFG, REG_DELAY, 18'd1, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh8000, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_CFG, REG_FEEDBACK, 18'd31130, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_CFG, REG_WET_MIX, 18'd32768, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh8000, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh8000, 16'sh7FFF, 1'b0, 16'sh0000, 16'sh0000},
		// Delays at the far end of the store tap entries that were never written.
		'{ROW_CFG, REG_DELAY, 18'd131072, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh4000, 16'shC000, 1'b1, 16'sh0000, 16'sh0000},
		'{ROW_CFG, REG_DELAY, 18'd131071, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh3FFF, 16'shC001, 1'b1, 16'sh0000, 16'sh0000},
		// No feedback, a delay of two and an even mix: small odd values exercise
		// the rounding of the mix.
		'{ROW_CFG, REG_FEEDBACK, 18'd0, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_CFG, REG_DELAY, 18'd2, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_CFG, REG_WET_MIX, 18'd16384, 16'sh0000, 16'sh0000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh0001, 16'shFFFF, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh0003, 16'shFFFD, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh4000, 16'shC000, 1'b0, 16'sh0000, 16'sh0000},
		'{ROW_PAIR, REG_DELAY, 18'd0, 16'sh7FFF, 16'sh8000, 1'b0, 16'sh0000, 16'sh0000}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	cfg_idx_t          cfg_idx;
	logic [CFG_DW-1:0] cfg_data;

	sfd_in_if  src_ch ();
	sfd_out_if snk_ch ();

	stereo_feedback_delay #(
		.STORE_DEPTH(ECHO_DEPTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.src      (src_ch),
		.snk      (snk_ch),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	// Predictor state: its own copy of the store, the write pointer and the three
	// registers. The store starts at zero, as the design's unwritten entries read.
	bit [31:0]         echo_mem [ECHO_DEPTH];
	int unsigned       wr_ptr = 0;
	logic [DELAY_W-1:0] cur_delay = DELAY_RESET;
	logic [FB_W-1:0]   cur_fb = FB_RESET;
	logic [MIX_W-1:0]  cur_wet = MIX_RESET;

	pair_t pending_mix [$];
	pair_t mix_want;
	int    mismatches = 0;
	int    cycle_count = 0;
	bit    src_idle_on = 1'b1;
	bit    snk_idle_on = 1'b1;
	int    stall_left = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic sample_t clip16(input longint v);
		if (v > 32767) begin
			return 16'sh7FFF;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return v[15:0];
	endfunction

	// Computes the mix for one accepted pair and updates the store and the write
	// pointer exactly as the block does. The tap is the entry delay places back;
	// a delay of zero, or one beyond the store, taps a full store depth back,
	// which is the entry about to be overwritten.
	function automatic pair_t echo_step(input sample_t l, input sample_t r);
		int unsigned tap;
		int unsigned rd;
		logic [31:0] word;
		longint x [2];
		longint d [2];
		longint g;
		longint w;
		longint f;
		longint m;
		sample_t kept [2];
		sample_t mixed [2];
		tap = cur_delay;
		if (tap == 0 || tap > ECHO_DEPTH) begin
			tap = ECHO_DEPTH;
		end
		rd = (wr_ptr + ECHO_DEPTH - tap) % ECHO_DEPTH;
		word = echo_mem[rd];
		d[0] = sample_t'(word[15:0]);
		d[1] = sample_t'(word[31:16]);
		x[0] = l;
		x[1] = r;
		g = (cur_fb > FB_MAX) ? FB_MAX : cur_fb;
		w = (cur_wet > ONE_Q15) ? ONE_Q15 : cur_wet;
		for (int c = 0; c < 2; c++) begin
			// Both products round half up through an arithmetic shift.
			f = (d[c] * g + 16384) >>> 15;
			m = x[c] * (32768 - w) + d[c] * w + 16384;
			kept[c] = clip16(x[c] + f);
			mixed[c] = clip16(m >>> 15);
		end
		echo_mem[wr_ptr] = {kept[1], kept[0]};
		wr_ptr = (wr_ptr + 1) % ECHO_DEPTH;
		return '{left: mixed[0], right: mixed[1]};
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Holds the sender back until every expected result has been taken, then waits
	// out the pipeline latency so the block is idle.
	task automatic settle();
		src_ch.valid <= 1'b0;
		while (pending_mix.size() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(posedge clk);
	endtask

	// Register writes happen only with the block idle. The mirror in the predictor
	// keeps only the bits the register holds; the unused index changes nothing.
	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DW-1:0] data);
		settle();
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_DELAY: begin
				cur_delay = data[DELAY_W-1:0];
			end
			REG_FEEDBACK: begin
				cur_fb = data[FB_W-1:0];
			end
			REG_WET_MIX: begin
				cur_wet = data[MIX_W-1:0];
			end
			default: begin
			end
		endcase
	endtask

	// Offers one pair and waits for its transfer. The predictor runs at the edge of
	// the transfer, so it sees the pairs in the order the block takes them. Valid
	// stays high into the next pair unless a gap burst is drawn.
	task automatic send_pair(input sample_t l, input sample_t r, input bit typed,
			input pair_t typed_mix);
		pair_t predicted;
		src_ch.valid <= 1'b1;
		src_ch.left_in <= l;
		src_ch.right_in <= r;
		do begin
			@(posedge clk);
		end while (!src_ch.ready);
		predicted = echo_step(l, r);
		pending_mix.push_back(typed ? typed_mix : predicted);
		if (src_idle_on && $urandom_range(0, 3) == 0) begin
			src_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Full-scale values and small values near zero are drawn more often than a flat
	// spread would give them.
	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0: begin
				return 16'sh7FFF;
			end
			1: begin
				return 16'sh8000;
			end
			2: begin
				return sample_t'($urandom_range(0, 512)) - 16'sd256;
			end
			default: begin
				return sample_t'($urandom_range(0, 65535));
			end
		endcase
	endfunction

	// Receiver: while stalling is on, ready drops for randomly drawn bursts.
	initial begin
		snk_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				stall_left--;
			end else if (snk_idle_on && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(1, 5);
			end
			snk_ch.ready <= (stall_left == 0);
		end
	end

	// Result checker: each transfer on the output is matched with the oldest
	// expectation, field by field.
	always @(posedge clk) begin
		if (arst_n && snk_ch.valid && snk_ch.ready) begin
			if (pending_mix.size() == 0) begin
				flag_mismatch($sformatf("result %0d/%0d with nothing expected",
					snk_ch.left_out, snk_ch.right_out));
			end else begin
				mix_want = pending_mix.pop_front();
				if (snk_ch.left_out !== mix_want.left) begin
					flag_mismatch($sformatf("left_out %0d, expected %0d",
						snk_ch.left_out, mix_want.left));
				end
				if (snk_ch.right_out !== mix_want.right) begin
					flag_mismatch($sformatf("right_out %0d, expected %0d",
						snk_ch.right_out, mix_want.right));
				end
			end
		end
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [CFG_DW-1:0] dval;
		logic [CFG_DW-1:0] fval;
		logic [CFG_DW-1:0] wval;
		bit quiet;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_DELAY;
		cfg_data <= '0;
		src_ch.valid <= 1'b0;
		src_ch.left_in <= '0;
		src_ch.right_in <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the table is walked in order, register rows and pair rows
		// interleaved.
		foreach (DIRECTED[i]) begin
			if (DIRECTED[i].kind == ROW_CFG) begin
				write_reg(DIRECTED[i].idx, DIRECTED[i].data);
			end else begin
				send_pair(DIRECTED[i].left, DIRECTED[i].right, DIRECTED[i].typed,
					'{left: DIRECTED[i].want_l, right: DIRECTED[i].want_r});
			end
		end

		// Random part: each phase draws new settings, mostly short delays so the
		// feedback builds up within a phase, with a share of delays long enough to
		// reach pairs written in earlier phases and of values beyond each range.
		// Upper bits of the write data beyond a register's width are random too.
		for (int ph = 0; ph < PHASES; ph++) begin
			quiet = (ph >= PHASES - 3);
			src_idle_on = !quiet && ($urandom_range(0, 4) != 0);
			snk_idle_on = !quiet && ($urandom_range(0, 4) != 0);
			case ($urandom_range(0, 19))
				0: begin
					dval = '0;
				end
				1: begin
					dval = ECHO_DEPTH;
				end
				2: begin
					dval = $urandom_range(ECHO_DEPTH + 1, 262143);
				end
				3: begin
					dval = ECHO_DEPTH - 1;
				end
				4, 5: begin
					dval = $urandom_range(65, 2000);
				end
				6, 7: begin
					dval = 1;
				end
				default: begin
					dval = $urandom_range(2, 64);
				end
			endcase
			fval = $urandom_range(0, 262143);
			case ($urandom_range(0, 7))
				0: begin
					fval[FB_W-1:0] = '0;
				end
				1: begin
					fval[FB_W-1:0] = FB_MAX;
				end
				2: begin
					fval[FB_W-1:0] = $urandom_range(FB_MAX + 1, 32767);
				end
				default: begin
					fval[FB_W-1:0] = $urandom_range(0, FB_MAX);
				end
			endcase
			wval = $urandom_range(0, 262143);
			case ($urandom_range(0, 7))
				0: begin
					wval[MIX_W-1:0] = '0;
				end
				1: begin
					wval[MIX_W-1:0] = ONE_Q15;
				end
				2: begin
					wval[MIX_W-1:0] = $urandom_range(ONE_Q15 + 1, 65535);
				end
				default: begin
					wval[MIX_W-1:0] = $urandom_range(0, ONE_Q15);
				end
			endcase
			write_reg(REG_DELAY, dval);
			write_reg(REG_FEEDBACK, fval);
			write_reg(REG_WET_MIX, wval);
			if ($urandom_range(0, 3) == 0) begin
				write_reg(REG_UNUSED, $urandom_range(0, 262143));
			end
			for (int k = 0; k < PAIRS_PER_PHASE; k++) begin
				// Once in the run the sender stops mid-phase until the output has
				// caught up completely, then resumes with the same settings.
				if (ph == 6 && k == PAIRS_PER_PHASE / 2) begin
					settle();
				end
				send_pair(pick_sample(), pick_sample(), 1'b0, '0);
			end
		end

		src_ch.valid <= 1'b0;
		while (pending_mix.size() != 0) begin
			@(posedge clk);
		end
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
